// ===== hdl/opt_pkg.sv =====
// Shared types and constants for the online perceptron trainer.
package opt_pkg;

  // Fixed widths of the stream fields.
  localparam int unsigned MAX_FEATURES     = 9;
  localparam int unsigned RAW_FEATURE_BITS = 8;
  localparam int unsigned LR_BITS          = 16;
  localparam int unsigned DELTA_BITS       = LR_BITS + 1;
  localparam int unsigned NET_BITS         = 48;
  localparam int unsigned OP_BITS          = 2;
  localparam int unsigned IN_DATA_BITS     =
    ((1 + MAX_FEATURES * RAW_FEATURE_BITS + 7) / 8) * 8;

  // Reset values.
  localparam logic [LR_BITS-1:0] LR_RESET = 16'd655;
  localparam int unsigned        ONE_Q16  = 65536;

  // Defaults for the top-level parameters.
  localparam int unsigned NUM_FEATURES_DEF = 9;
  localparam int unsigned FEATURE_BITS_DEF = 8;
  localparam int unsigned WEIGHT_BITS_DEF  = 32;

  // Operation codes; the unused code acts as predict.
  typedef enum logic [OP_BITS-1:0] {
    OP_PREDICT = 2'd0,
    OP_TRAIN   = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  // Write command from the merge stage to every lane.
  typedef struct packed {
    logic fire;   // a result leaves the merge stage this cycle
    logic train;  // apply the step to the weight
    logic add;    // step direction: 1 adds, 0 subtracts
    logic clear;  // load the clear value
  } opt_commit_t;

endpackage

// ===== hdl/opt_lane.sv =====
// One weight lane: holds a weight, forms its product and its update.
module opt_lane import opt_pkg::*; #(
  parameter int unsigned FEATURE_BITS = FEATURE_BITS_DEF,
  parameter int unsigned WEIGHT_BITS  = WEIGHT_BITS_DEF,
  parameter logic [WEIGHT_BITS-1:0] CLEAR_VALUE = '0,
  localparam int unsigned PROD_W = WEIGHT_BITS + FEATURE_BITS + 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  logic [FEATURE_BITS-1:0]  feature_i,
  input  logic [DELTA_BITS-1:0]    delta_i,
  input  opt_commit_t              commit_i,
  output logic signed [PROD_W-1:0] product_o
);

  localparam int unsigned STEP_W = FEATURE_BITS + DELTA_BITS;
  localparam int unsigned SUM_W  =
    ((WEIGHT_BITS > STEP_W + 1) ? WEIGHT_BITS : STEP_W + 1) + 1;
  localparam logic signed [SUM_W-1:0] W_MAX =
    SUM_W'($signed({1'b0, {(WEIGHT_BITS-1){1'b1}}}));
  localparam logic signed [SUM_W-1:0] W_MIN =
    SUM_W'($signed({1'b1, {(WEIGHT_BITS-1){1'b0}}}));

  logic signed [WEIGHT_BITS-1:0] weight_q, weight_d;
  logic signed [PROD_W-1:0]      prod_q, prod_d;
  logic [STEP_W-1:0]             step_q, step_d;
  logic signed [SUM_W-1:0]       w_ext, step_ext, sum;

  // Product for the net sum and the update magnitude, formed at accept.
  assign prod_d = $signed(weight_q) * $signed({1'b0, feature_i});
  assign step_d = STEP_W'(feature_i) * STEP_W'(delta_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
      step_q <= step_d;
    end
  end

  // Saturating weight update, or a load of the clear value.
  always_comb begin
    w_ext    = SUM_W'(weight_q);
    step_ext = SUM_W'($signed({1'b0, step_q}));
    sum      = commit_i.add ? (w_ext + step_ext) : (w_ext - step_ext);
    weight_d = weight_q;
    if (commit_i.clear) begin
      weight_d = CLEAR_VALUE;
    end else if (commit_i.train) begin
      if (sum > W_MAX) begin
        weight_d = W_MAX[WEIGHT_BITS-1:0];
      end else if (sum < W_MIN) begin
        weight_d = W_MIN[WEIGHT_BITS-1:0];
      end else begin
        weight_d = sum[WEIGHT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= CLEAR_VALUE;
    end else if (commit_i.fire) begin
      weight_q <= weight_d;
    end
  end

  assign product_o = prod_q;

  // The weight only moves when a result is committed.
  a_weight_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit_i.fire |=> $stable(weight_q))
    else $error("weight changed without a commit");

endmodule

// ===== hdl/opt_merge.sv =====
// Merge stage: sums the lane products, predicts and decides the update.
module opt_merge import opt_pkg::*; #(
  parameter int unsigned NUM_TERMS = NUM_FEATURES_DEF + 1,
  parameter int unsigned PROD_W    = WEIGHT_BITS_DEF + FEATURE_BITS_DEF + 1
) (
  input  logic signed [PROD_W-1:0]   prod_i [NUM_TERMS],
  input  logic                       fire_i,
  input  op_e                        op_i,
  input  logic                       label_i,
  input  logic                       lr_nonzero_i,
  output logic                       pred_o,
  output logic                       update_o,
  output logic signed [NET_BITS-1:0] net_o,
  output opt_commit_t                commit_o
);

  localparam int unsigned SUM_W = PROD_W + $clog2(NUM_TERMS) + 1;
  localparam int unsigned NPAIR = (NUM_TERMS + 1) / 2;

  logic signed [SUM_W-1:0] pair [NPAIR];
  logic signed [SUM_W-1:0] level [NPAIR];
  logic signed [SUM_W-1:0] sum;

  // First tree level: independent pair sums.
  for (genvar k = 0; k < NPAIR; k++) begin : g_pair
    if (2 * k + 1 < NUM_TERMS) begin : g_two
      assign pair[k] = SUM_W'(prod_i[2*k]) + SUM_W'(prod_i[2*k+1]);
    end else begin : g_one
      assign pair[k] = SUM_W'(prod_i[2*k]);
    end
  end

  // Remaining levels: a pairwise tree over the pair sums.
  always_comb begin
    level = pair;
    for (int unsigned s = 1; s < NPAIR; s = s * 2) begin
      for (int unsigned k = 0; k + s < NPAIR; k = k + 2 * s) begin
        level[k] = level[k] + level[k + s];
      end
    end
    sum = level[0];
  end

  // Net sum limited to the result width; the sign is kept.
  if (SUM_W > NET_BITS) begin : g_clamp
    localparam logic signed [SUM_W-1:0] N_MAX =
      SUM_W'($signed({1'b0, {(NET_BITS-1){1'b1}}}));
    localparam logic signed [SUM_W-1:0] N_MIN =
      SUM_W'($signed({1'b1, {(NET_BITS-1){1'b0}}}));
    always_comb begin
      if (sum > N_MAX) begin
        net_o = N_MAX[NET_BITS-1:0];
      end else if (sum < N_MIN) begin
        net_o = N_MIN[NET_BITS-1:0];
      end else begin
        net_o = sum[NET_BITS-1:0];
      end
    end
  end else begin : g_ext
    assign net_o = NET_BITS'(sum);
  end

  assign pred_o = ~sum[SUM_W-1];

  // Training applies only on a misclassified train word with a nonzero rate.
  always_comb begin
    update_o = 1'b0;
    commit_o = '0;
    case (op_i)
      OP_TRAIN: update_o = (pred_o != label_i) && lr_nonzero_i;
      default:  update_o = 1'b0;
    endcase
    commit_o.fire  = fire_i;
    commit_o.train = fire_i && update_o;
    commit_o.add   = label_i;
    commit_o.clear = fire_i && (op_i == OP_CLEAR);
  end

endmodule

// ===== hdl/online_perceptron_trainer.sv =====
// Top level of the online perceptron trainer: stream ports, lanes and merge.
//
// Usage: each input word on the s_axis channel carries one sample (label and
// nine 8-bit features in tdata, the operation in tuser). The block answers
// every word with one result word on the m_axis channel: the prediction, a
// flag telling whether training changed the model, and the 48-bit net sum.
// In the accept cycle every lane multiplies its weight by its feature and
// by the update step and registers both; once the output register is free,
// the merge stage adds the lane products, predicts and writes the weights
// back. The next word depends on those weights, so a new word is taken only
// in the cycle after the previous word leaves the merge stage.
// The result sits in an output register, so a stalled receiver holds only
// that register; one further word is accepted and then waits in the lanes
// until the output register is free.
// The user must write the learning rate through cfg_we_i / cfg_wdata_i only
// while idle; the block itself does not enforce this. Reset clears the
// weights to zero, the bias to 1.0 and the rate to 655.
module online_perceptron_trainer import opt_pkg::*; #(
  parameter int unsigned NUM_FEATURES = NUM_FEATURES_DEF,
  parameter int unsigned FEATURE_BITS = FEATURE_BITS_DEF,
  parameter int unsigned WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Learning rate register.
  input  logic                    cfg_we_i,
  input  logic [LR_BITS-1:0]      cfg_wdata_i,
  // Sample input.
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // tdata: label, feature_0 .. feature_8 (8 bits each), zero padding.
  input  logic [IN_DATA_BITS-1:0] s_axis_tdata_i,
  // tuser: operation.
  input  logic [OP_BITS-1:0]      s_axis_tuser_i,
  // Result output.
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // tdata: net_sum.
  output logic [NET_BITS-1:0]     m_axis_tdata_o,
  // tuser: predicted_class, was_updated.
  output logic [1:0]              m_axis_tuser_o
);

  localparam int unsigned NUM_TERMS = NUM_FEATURES + 1;
  localparam int unsigned PROD_W    = WEIGHT_BITS + FEATURE_BITS + 1;
  localparam logic [WEIGHT_BITS-1:0] BIAS_ONE = (WEIGHT_BITS > 17) ?
    WEIGHT_BITS'(ONE_Q16) : {1'b0, {(WEIGHT_BITS-1){1'b1}}};

  logic [LR_BITS-1:0]       lr_q;
  logic                     busy_q;
  op_e                      op_q;
  logic                     label_q;
  logic                     m_valid_q;
  logic [NET_BITS-1:0]      net_q;
  logic                     pred_q, upd_q;

  logic                     accept, fire;
  logic [DELTA_BITS-1:0]    delta;
  logic [FEATURE_BITS-1:0]  feat [NUM_TERMS];
  logic signed [PROD_W-1:0] prod [NUM_TERMS];
  logic                     pred, update;
  logic signed [NET_BITS-1:0] net;
  opt_commit_t              commit;

  // Handshake: one word in the lanes at a time.
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = ~busy_q;
  assign fire            = busy_q && (!m_valid_q || m_axis_tready_i);
  assign delta           = {lr_q, 1'b0};

  // Learning rate register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= LR_RESET;
    end else if (cfg_we_i) begin
      lr_q <= cfg_wdata_i;
    end
  end

  // Lane stage control and sample payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (fire) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(s_axis_tuser_i);
      label_q <= s_axis_tdata_i[0];
    end
  end

  // Feature extraction, masked to the lane width.
  for (genvar k = 0; k < NUM_FEATURES; k++) begin : g_feat
    if (FEATURE_BITS >= RAW_FEATURE_BITS) begin : g_wide
      assign feat[k] =
        FEATURE_BITS'(s_axis_tdata_i[1 + k*RAW_FEATURE_BITS +: RAW_FEATURE_BITS]);
    end else begin : g_narrow
      assign feat[k] = s_axis_tdata_i[1 + k*RAW_FEATURE_BITS +: FEATURE_BITS];
    end
  end
  assign feat[NUM_FEATURES] = FEATURE_BITS'(1);

  // Weight lanes and the bias lane, which sees a constant feature of one.
  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_lane
    opt_lane #(
      .FEATURE_BITS(FEATURE_BITS),
      .WEIGHT_BITS (WEIGHT_BITS),
      .CLEAR_VALUE ((k == NUM_FEATURES) ? BIAS_ONE : '0)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .load_i   (accept),
      .feature_i(feat[k]),
      .delta_i  (delta),
      .commit_i (commit),
      .product_o(prod[k])
    );
  end

  opt_merge #(
    .NUM_TERMS(NUM_TERMS),
    .PROD_W   (PROD_W)
  ) u_merge (
    .prod_i      (prod),
    .fire_i      (fire),
    .op_i        (op_q),
    .label_i     (label_q),
    .lr_nonzero_i(lr_q != '0),
    .pred_o      (pred),
    .update_o    (update),
    .net_o       (net),
    .commit_o    (commit)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      net_q  <= net;
      pred_q <= pred;
      upd_q  <= update;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = net_q;
  assign m_axis_tuser_o  = {upd_q, pred_q};

  // An accepted word always reaches the merge stage next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && !s_axis_tready_o)
    else $error("accepted word did not enter the lanes");

  // A committed result is presented in the following cycle.
  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid_o && (m_axis_tuser_o[1] == $past(commit.train)))
    else $error("committed result missing at the output");

  // Training and clearing never happen together, and only on a commit.
  a_commit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit.train || commit.clear) |-> commit.fire && !(commit.train && commit.clear))
    else $error("inconsistent lane commit");

  // An update is only reported with a nonzero learning rate.
  a_update_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit.train |-> (lr_q != '0) && (op_q == OP_TRAIN))
    else $error("update without training rate");

endmodule
